// File: hdl/dstk_pkg.sv
// dstk_pkg: shared constants and types for the dual-ended stack.
// Used by dstk_ctrl, dstk_dpath and dual_ended_stack_top. No dependencies.
`default_nettype none

package dstk_pkg;

    localparam int DEPTH_DEF = 1024;

    // fixed field widths
    localparam int CMD_W  = 3;
    localparam int DATA_W = 32;
    localparam int POS_W  = 11;
    localparam int CAP_W  = 11;
    localparam int STAT_W = 2;

    // stream payload widths, rounded up to whole bytes
    localparam int S_TDATA_W = ((CMD_W + DATA_W + POS_W + 7) / 8) * 8;
    localparam int M_TDATA_W = ((DATA_W + STAT_W + 7) / 8) * 8;

    localparam int CAP_RESET = 1024;

    // commands
    localparam logic [CMD_W-1:0] CMD_PUSH_LO = 3'd0;
    localparam logic [CMD_W-1:0] CMD_POP_LO  = 3'd1;
    localparam logic [CMD_W-1:0] CMD_PUSH_HI = 3'd2;
    localparam logic [CMD_W-1:0] CMD_POP_HI  = 3'd3;
    localparam logic [CMD_W-1:0] CMD_PEEK_LO = 3'd4;

    // result status
    localparam logic [STAT_W-1:0] ST_OK     = 2'd0;
    localparam logic [STAT_W-1:0] ST_FULL   = 2'd1;
    localparam logic [STAT_W-1:0] ST_EMPTY  = 2'd2;
    localparam logic [STAT_W-1:0] ST_BADPOS = 2'd3;

    localparam logic [DATA_W-1:0] MIN_WORD = 32'h8000_0000;

    // controller -> datapath
    typedef struct packed {
        logic accept;    // input transfer this cycle
        logic load_rd;   // move registered memory read data to output
    } t_ctl_cmd;

    // datapath -> controller
    typedef struct packed {
        logic out_busy;  // output register holds a result not taken this cycle
        logic needs_rd;  // offered command needs a memory read
    } t_dp_stat;

endpackage

`default_nettype wire

// File: hdl/dual_ended_stack_top.sv
// dual_ended_stack_top: two stacks sharing one memory, stream in / stream out.
// Depends on dstk_pkg, dstk_ctrl, dstk_dpath.
//
//   port group       dir  payload (low bit first)
//   i_s_t*           in   cmd[2:0], data_in[34:3], position[45:35], zero fill
//   o_m_t*           out  data_out[31:0], status[33:32], zero fill
//   i_cfg_*          in   capacity[10:0], written when i_cfg_we is high
//
// Push, failed pop/peek and unused commands load their result into the output
// register when taken; successful pops and peeks go through the registered read port of the memory first.
// A new command is taken while the previous result waits, as long as no memory read
// is pending and that result leaves the output register in the same cycle.
// Reset (i_rst_n low, synchronous) empties both stacks and sets capacity to
// 1024 (or DEPTH if smaller); the memory needs no clearing pass.
`default_nettype none

module dual_ended_stack_top
    import dstk_pkg::*;
#(
    parameter int DEPTH = DEPTH_DEF
) (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 i_cfg_we,
    input  wire logic [CAP_W-1:0]     i_cfg_wdata,     // capacity
    input  wire logic                 i_s_tvalid,
    output logic                      o_s_tready,
    input  wire logic [S_TDATA_W-1:0] i_s_tdata,       // cmd, data_in, position
    output logic                      o_m_tvalid,
    input  wire logic                 i_m_tready,
    output logic [M_TDATA_W-1:0]      o_m_tdata        // data_out, status
);

    t_ctl_cmd          ctl;
    t_dp_stat          stat;
    logic [DATA_W-1:0] data_out;
    logic [STAT_W-1:0] status;

    dstk_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .i_stat     (stat),
        .o_cmd      (ctl)
    );

    dstk_dpath #(
        .DEPTH (DEPTH)
    ) u_dpath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .i_cmd       (i_s_tdata[CMD_W-1:0]),
        .i_data_in   (i_s_tdata[CMD_W+DATA_W-1:CMD_W]),
        .i_position  (i_s_tdata[CMD_W+DATA_W+POS_W-1:CMD_W+DATA_W]),
        .i_ctl       (ctl),
        .o_stat      (stat),
        .o_m_tvalid  (o_m_tvalid),
        .i_m_tready  (i_m_tready),
        .o_data_out  (data_out),
        .o_status    (status)
    );

    assign o_m_tdata = {{(M_TDATA_W-DATA_W-STAT_W){1'b0}}, status, data_out};

endmodule

`default_nettype wire

// File: hdl/dstk_ctrl.sv
// dstk_ctrl: sequencing state machine for the dual-ended stack.
// Depends on dstk_pkg (command/status structs).
`default_nettype none

module dstk_ctrl
    import dstk_pkg::*;
(
    input  wire logic     i_clk,
    input  wire logic     i_rst_n,
    input  wire logic     i_s_tvalid,
    output logic          o_s_tready,
    input  wire t_dp_stat i_stat,
    output t_ctl_cmd      o_cmd
);

    localparam logic S_IDLE = 1'b0;
    localparam logic S_READ = 1'b1;

    logic r_state;
    logic n_state;

    always_comb begin
        o_s_tready    = (r_state == S_IDLE) && !i_stat.out_busy;
        o_cmd.accept  = o_s_tready && i_s_tvalid;
        o_cmd.load_rd = (r_state == S_READ);
        n_state       = r_state;
        case (r_state)
            S_IDLE: begin
                if (o_cmd.accept && i_stat.needs_rd) begin
                    n_state = S_READ;
                end
            end
            S_READ: begin
                n_state = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

endmodule

`default_nettype wire

// File: hdl/dstk_dpath.sv
// dstk_dpath: pointers, capacity register, shared stack memory and output register.
// Depends on dstk_pkg; driven by dstk_ctrl.
`default_nettype none

module dstk_dpath
    import dstk_pkg::*;
#(
    parameter int DEPTH = DEPTH_DEF
) (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_cfg_we,
    input  wire logic [CAP_W-1:0]  i_cfg_wdata,
    input  wire logic [CMD_W-1:0]  i_cmd,
    input  wire logic [DATA_W-1:0] i_data_in,
    input  wire logic [POS_W-1:0]  i_position,
    input  wire t_ctl_cmd          i_ctl,
    output t_dp_stat               o_stat,
    output logic                   o_m_tvalid,
    input  wire logic              i_m_tready,
    output logic [DATA_W-1:0]      o_data_out,
    output logic [STAT_W-1:0]      o_status
);

    localparam int CW = $clog2(DEPTH + 1);     // counts 0..DEPTH
    localparam int MW = $clog2(DEPTH);         // memory address
    localparam int PW = (CW > POS_W) ? CW : POS_W;
    localparam logic [CW-1:0] CAP_INIT =
        (CAP_RESET > DEPTH) ? CW'(DEPTH) : CW'(CAP_RESET);
    localparam logic [CW-1:0] ONE = CW'(1);

    logic [DATA_W-1:0] r_mem [DEPTH];

    logic [CW-1:0]     r_cap;
    logic [CW-1:0]     r_low;
    logic [CW-1:0]     r_high;
    logic [CW-1:0]     n_low;
    logic [CW-1:0]     n_high;
    logic [DATA_W-1:0] r_rd_data;
    logic              r_out_valid;
    logic [DATA_W-1:0] r_out_data;
    logic [STAT_W-1:0] r_out_stat;

    logic [31:0]       cfg_ext;
    logic [CW-1:0]     cap_new;
    logic [PW-1:0]     pos_ext;
    logic [PW-1:0]     low_ext;
    logic              has_room;
    logic              low_empty;
    logic              high_empty;
    logic              pos_bad;
    logic              do_wr;
    logic [MW-1:0]     wr_addr;
    logic [MW-1:0]     rd_addr;
    logic [CW-1:0]     peek_idx;
    logic              needs_rd;
    logic [DATA_W-1:0] imm_data;
    logic [STAT_W-1:0] imm_stat;

    always_comb begin
        cfg_ext  = {{(32-CAP_W){1'b0}}, i_cfg_wdata};
        cap_new  = (cfg_ext > 32'(DEPTH)) ? CW'(DEPTH) : CW'(cfg_ext);
        pos_ext  = PW'(i_position);
        low_ext  = PW'(r_low);
        has_room   = (r_low < r_high);
        low_empty  = (r_low == '0);
        high_empty = (r_high >= r_cap);
        pos_bad    = (pos_ext == '0) || (pos_ext > low_ext);
        peek_idx   = r_low - CW'(i_position);

        do_wr    = 1'b0;
        wr_addr  = MW'(r_low);
        rd_addr  = MW'(r_high);
        needs_rd = 1'b0;
        imm_data = '0;
        imm_stat = ST_OK;
        n_low    = r_low;
        n_high   = r_high;
        case (i_cmd)
            CMD_PUSH_LO: begin
                if (has_room) begin
                    do_wr   = 1'b1;
                    wr_addr = MW'(r_low);
                    n_low   = r_low + ONE;
                end else begin
                    imm_stat = ST_FULL;
                end
            end
            CMD_POP_LO: begin
                if (low_empty) begin
                    imm_stat = ST_EMPTY;
                end else begin
                    needs_rd = 1'b1;
                    rd_addr  = MW'(r_low - ONE);
                    n_low    = r_low - ONE;
                end
            end
            CMD_PUSH_HI: begin
                if (has_room) begin
                    do_wr   = 1'b1;
                    wr_addr = MW'(r_high - ONE);
                    n_high  = r_high - ONE;
                end else begin
                    imm_stat = ST_FULL;
                end
            end
            CMD_POP_HI: begin
                if (high_empty) begin
                    imm_stat = ST_EMPTY;
                end else begin
                    needs_rd = 1'b1;
                    rd_addr  = MW'(r_high);
                    n_high   = r_high + ONE;
                end
            end
            CMD_PEEK_LO: begin
                if (pos_bad) begin
                    imm_data = MIN_WORD;
                    imm_stat = ST_BADPOS;
                end else begin
                    needs_rd = 1'b1;
                    rd_addr  = MW'(peek_idx);
                end
            end
            default: begin
            end
        endcase

        o_stat.out_busy = r_out_valid && !i_m_tready;
        o_stat.needs_rd = needs_rd;
    end

    // shared memory: one write port, one registered read port
    always_ff @(posedge i_clk) begin
        if (i_ctl.accept && do_wr) begin
            r_mem[wr_addr] <= i_data_in;
        end
        if (i_ctl.accept && needs_rd) begin
            r_rd_data <= r_mem[rd_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cap  <= CAP_INIT;
            r_low  <= '0;
            r_high <= CAP_INIT;
        end else if (i_cfg_we) begin
            // new capacity empties both stacks
            r_cap  <= cap_new;
            r_low  <= '0;
            r_high <= cap_new;
        end else if (i_ctl.accept) begin
            r_low  <= n_low;
            r_high <= n_high;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_ctl.load_rd || (i_ctl.accept && !needs_rd)) begin
            r_out_valid <= 1'b1;
        end else if (i_m_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.load_rd) begin
            r_out_data <= r_rd_data;
            r_out_stat <= ST_OK;
        end else if (i_ctl.accept && !needs_rd) begin
            r_out_data <= imm_data;
            r_out_stat <= imm_stat;
        end
    end

    assign o_m_tvalid = r_out_valid;
    assign o_data_out = r_out_data;
    assign o_status   = r_out_stat;

endmodule

`default_nettype wire

// File: bench/tb.sv
// tb: self-checking bench for dual_ended_stack_top, with its own model of both stacks.
// Covers directed corners, a full-memory fill, and random command mixes under stalls.
// Depends on dstk_pkg and dual_ended_stack_top.
`timescale 1ns / 1ps

module tb;
    import dstk_pkg::*;

    localparam int MEM_DEPTH   = DEPTH_DEF;
    localparam int STALL_LIMIT = 3000;
    localparam int IDLE_PCT    = 38;

    typedef struct packed {
        logic [DATA_W-1:0] data_out;
        logic [STAT_W-1:0] status;
    } t_stack_result;

    logic                 clk = 1'b0;
    logic                 rst_n = 1'b0;
    logic                 cfg_we = 1'b0;
    logic [CAP_W-1:0]     cfg_wdata = '0;
    logic                 s_tvalid = 1'b0;
    logic                 s_tready;
    logic [S_TDATA_W-1:0] s_tdata = '0;
    logic                 m_tvalid;
    logic                 m_tready = 1'b0;
    logic [M_TDATA_W-1:0] m_tdata;

    // model state
    logic [DATA_W-1:0] stack_mem [MEM_DEPTH];
    int unsigned       lo_cnt;
    int unsigned       hi_base;
    int unsigned       capacity;

    t_stack_result     expected_results[$];
    int                fail_count = 0;
    int                stall_cycles = 0;
    bit                no_idle = 1'b0;
    int                hold_request = 0;
    int                hold_left = 0;

    dual_ended_stack_top dut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_cfg_we    (cfg_we),
        .i_cfg_wdata (cfg_wdata),
        .i_s_tvalid  (s_tvalid),
        .o_s_tready  (s_tready),
        .i_s_tdata   (s_tdata),
        .o_m_tvalid  (m_tvalid),
        .i_m_tready  (m_tready),
        .o_m_tdata   (m_tdata)
    );

    initial begin
        forever #5 clk = ~clk;
    end

    function automatic t_stack_result stack_predict(input logic [CMD_W-1:0] cmd,
                                                    input logic [DATA_W-1:0] din,
                                                    input logic [POS_W-1:0] pos);
        t_stack_result r;
        r.data_out = '0;
        r.status   = ST_OK;
        case (cmd)
            CMD_PUSH_LO: begin
                if (lo_cnt < hi_base && lo_cnt < MEM_DEPTH) begin
                    stack_mem[lo_cnt] = din;
                    lo_cnt++;
                end else begin
                    r.status = ST_FULL;
                end
            end
            CMD_POP_LO: begin
                if (lo_cnt == 0) begin
                    r.status = ST_EMPTY;
                end else begin
                    lo_cnt--;
                    r.data_out = stack_mem[lo_cnt];
                end
            end
            CMD_PUSH_HI: begin
                if (lo_cnt < hi_base && hi_base > 0) begin
                    hi_base--;
                    stack_mem[hi_base] = din;
                end else begin
                    r.status = ST_FULL;
                end
            end
            CMD_POP_HI: begin
                if (hi_base >= capacity || hi_base >= MEM_DEPTH) begin
                    r.status = ST_EMPTY;
                end else begin
                    r.data_out = stack_mem[hi_base];
                    hi_base++;
                end
            end
            CMD_PEEK_LO: begin
                if (pos == 0 || pos > lo_cnt) begin
                    r.data_out = MIN_WORD;
                    r.status   = ST_BADPOS;
                end else begin
                    r.data_out = stack_mem[lo_cnt - pos];
                end
            end
            default: ;
        endcase
        return r;
    endfunction

    // result checker
    always @(posedge clk) begin
        t_stack_result want;
        if (m_tvalid && m_tready) begin
            if (expected_results.size() == 0) begin
                $error("result transfer with nothing expected: tdata %h", m_tdata);
                fail_count++;
            end else begin
                want = expected_results.pop_front();
                if (m_tdata[DATA_W-1:0] !== want.data_out) begin
                    $error("data_out: expected %h, got %h", want.data_out,
                           m_tdata[DATA_W-1:0]);
                    fail_count++;
                end
                if (m_tdata[DATA_W+STAT_W-1:DATA_W] !== want.status) begin
                    $error("status: expected %0d, got %0d", want.status,
                           m_tdata[DATA_W+STAT_W-1:DATA_W]);
                    fail_count++;
                end
            end
        end
    end

    // receiver: random stalls, plus long hold-offs on request
    always @(posedge clk) begin
        if (hold_request > 0) begin
            hold_left = hold_request;
            hold_request = 0;
        end
        if (hold_left > 0) begin
            hold_left--;
            m_tready <= 1'b0;
        end else begin
            m_tready <= no_idle || ($urandom_range(0, 99) >= IDLE_PCT);
        end
    end

    // watchdog on cycles with no transfer at all
    always @(posedge clk) begin
        if (!rst_n || cfg_we || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
            stall_cycles <= 0;
        end else if (stall_cycles >= STALL_LIMIT) begin
            $display("Mismatches found");
            $finish;
        end else begin
            stall_cycles <= stall_cycles + 1;
        end
    end

    task automatic send_cmd(input logic [CMD_W-1:0] cmd, input logic [DATA_W-1:0] din,
                            input logic [POS_W-1:0] pos);
        logic [S_TDATA_W-1:0] word;
        word = '0;
        word[CMD_W-1:0] = cmd;
        word[CMD_W+DATA_W-1:CMD_W] = din;
        word[CMD_W+DATA_W+POS_W-1:CMD_W+DATA_W] = pos;
        if (!no_idle) begin
            while ($urandom_range(0, 99) < IDLE_PCT) begin
                s_tvalid <= 1'b0;
                @(posedge clk);
            end
        end
        s_tvalid <= 1'b1;
        s_tdata  <= word;
        do @(posedge clk); while (!s_tready);
        expected_results.push_back(stack_predict(cmd, din, pos));
    endtask

    // random command, with positions biased toward peeks that land inside the low stack
    task automatic send_random_cmd();
        int unsigned          r;
        logic [CMD_W-1:0]     cmd;
        logic [POS_W-1:0]     pos;
        r = $urandom_range(0, 99);
        if (r < 25)      cmd = CMD_PUSH_LO;
        else if (r < 45) cmd = CMD_POP_LO;
        else if (r < 65) cmd = CMD_PUSH_HI;
        else if (r < 80) cmd = CMD_POP_HI;
        else if (r < 95) cmd = CMD_PEEK_LO;
        else             cmd = CMD_W'($urandom_range(5, 7));
        r = $urandom_range(0, 99);
        if (r < 70 && lo_cnt > 0) pos = POS_W'($urandom_range(1, lo_cnt));
        else if (r < 80)          pos = '0;
        else if (r < 90)          pos = POS_W'(lo_cnt + 1);
        else                      pos = POS_W'($urandom_range(0, 2047));
        send_cmd(cmd, $urandom, pos);
    endtask

    task automatic wait_drained();
        s_tvalid <= 1'b0;
        while (expected_results.size() != 0) @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic write_capacity(input logic [CAP_W-1:0] value);
        wait_drained();
        cfg_we    <= 1'b1;
        cfg_wdata <= value;
        @(posedge clk);
        cfg_we    <= 1'b0;
        capacity = (value > MEM_DEPTH) ? MEM_DEPTH : value;
        lo_cnt   = 0;
        hi_base  = capacity;
    endtask

    task automatic test_empty_and_peek();
        send_cmd(CMD_POP_LO, '0, '0);
        send_cmd(CMD_POP_HI, '0, '0);
        send_cmd(CMD_PEEK_LO, '0, 11'd0);
        send_cmd(CMD_PEEK_LO, '0, 11'd1);
        send_cmd(CMD_PUSH_LO, 32'h7fff_ffff, '0);
        send_cmd(CMD_PUSH_LO, 32'h8000_0000, 11'h7ff);
        send_cmd(CMD_PUSH_HI, 32'hffff_ffff, '0);
        send_cmd(CMD_PUSH_HI, 32'h0000_0000, '0);
        send_cmd(CMD_PEEK_LO, '0, 11'd1);
        send_cmd(CMD_PEEK_LO, '0, 11'd2);
        send_cmd(CMD_PEEK_LO, '0, 11'd3);
        send_cmd(CMD_PEEK_LO, '0, 11'h7ff);
        send_cmd(CMD_W'(5), $urandom, '0);
        send_cmd(CMD_W'(6), $urandom, '0);
        send_cmd(CMD_W'(7), $urandom, '0);
        send_cmd(CMD_POP_HI, '0, '0);
        send_cmd(CMD_POP_LO, '0, '0);
        send_cmd(CMD_POP_LO, '0, '0);
        send_cmd(CMD_POP_LO, '0, '0);
    endtask

    task automatic test_tiny_capacity();
        write_capacity(11'd2);
        send_cmd(CMD_PUSH_LO, $urandom, '0);
        send_cmd(CMD_PUSH_HI, $urandom, '0);
        send_cmd(CMD_PUSH_LO, $urandom, '0);
        send_cmd(CMD_PUSH_HI, $urandom, '0);
        send_cmd(CMD_POP_HI, '0, '0);
        send_cmd(CMD_POP_LO, '0, '0);
        write_capacity(11'd1);
        send_cmd(CMD_PUSH_HI, $urandom, '0);
        send_cmd(CMD_PUSH_LO, $urandom, '0);
        send_cmd(CMD_POP_HI, '0, '0);
        write_capacity(11'd0);
        send_cmd(CMD_PUSH_LO, $urandom, '0);
        send_cmd(CMD_PUSH_HI, $urandom, '0);
        send_cmd(CMD_POP_HI, '0, '0);
        send_cmd(CMD_POP_LO, '0, '0);
        // above the memory size saturates
        write_capacity(11'h7ff);
        send_cmd(CMD_PUSH_HI, $urandom, '0);
        send_cmd(CMD_POP_HI, '0, '0);
    endtask

    task automatic test_full_memory();
        write_capacity(CAP_W'(MEM_DEPTH));
        for (int i = 0; i < MEM_DEPTH; i++) begin
            send_cmd(CMD_PUSH_LO, $urandom, '0);
            if (i % 8 == 7) send_cmd(CMD_PEEK_LO, '0, POS_W'($urandom_range(1, lo_cnt)));
        end
        send_cmd(CMD_PEEK_LO, '0, POS_W'(MEM_DEPTH));
        send_cmd(CMD_PEEK_LO, '0, POS_W'(MEM_DEPTH + 1));
        send_cmd(CMD_PUSH_LO, $urandom, '0);
        send_cmd(CMD_PUSH_HI, $urandom, '0);
        send_cmd(CMD_POP_HI, '0, '0);
        send_cmd(CMD_POP_LO, '0, '0);
    endtask

    task automatic test_random_mix(input logic [CAP_W-1:0] cap, input int count);
        write_capacity(cap);
        repeat (count) send_random_cmd();
    endtask

    task automatic test_output_holdoff();
        hold_request = 400;
        repeat (40) send_random_cmd();
        wait_drained();
    endtask

    task automatic test_no_idle_burst();
        no_idle = 1'b1;
        repeat (150) send_random_cmd();
        no_idle = 1'b0;
    endtask

    initial begin
        capacity = (CAP_RESET > MEM_DEPTH) ? MEM_DEPTH : CAP_RESET;
        lo_cnt   = 0;
        hi_base  = capacity;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_empty_and_peek();
        test_tiny_capacity();
        test_full_memory();
        test_random_mix(11'd2, 60);
        test_random_mix(11'd3, 60);
        test_random_mix(CAP_W'($urandom_range(4, 12)), 70);
        test_output_holdoff();
        test_random_mix(CAP_W'($urandom_range(13, 40)), 70);
        test_no_idle_burst();
        test_random_mix(CAP_W'($urandom_range(2, 1024)), 60);
        test_random_mix(CAP_W'($urandom_range(0, 2047)), 60);
        test_random_mix(CAP_W'(MEM_DEPTH), 60);
        test_random_mix(11'd5, 80);
        test_random_mix(11'd8, 80);

        wait_drained();
        repeat (10) @(posedge clk);
        if (fail_count == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end

endmodule

// File: dual_ended_stack_top.f
hdl/dstk_pkg.sv
hdl/dstk_ctrl.sv
hdl/dstk_dpath.sv
hdl/dual_ended_stack_top.sv
bench/tb.sv
